### sv/voxel_quantize_dedup_macros.svh
// Assertion macros shared by the voxel quantize and dedup block
`ifndef VOXEL_QUANTIZE_DEDUP_MACROS_SVH
`define VOXEL_QUANTIZE_DEDUP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge out of reset
`define VQD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vqd check failed");
// next-cycle implication
`define VQD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vqd check failed");
`else
`define VQD_ASSERT_NOW(lbl, ante, cons)
`define VQD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/vqd_pkg.sv
// Shared types and constants of the voxel quantize and dedup block
package vqd_pkg;

	localparam int MAX_VOXELS = 1024;
	localparam int ADDR_W = $clog2(MAX_VOXELS);
	localparam int CNT_W = ADDR_W + 1;
	localparam int COORD_W = 32;
	localparam int SIZE_W = 31;
	localparam int NUM_W = COORD_W + 2;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam logic [SIZE_W-1:0] VOXEL_SIZE_RESET = 31'd65536;
	localparam int RAM_W = 3 * COORD_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} voxel_t;

	typedef struct packed {
		voxel_t vox;
		logic   fin;
	} mid_item_t;

	typedef enum logic [1:0] {
		ROW_NEW  = 2'd0,
		ROW_SEAL = 2'd1,
		ROW_END  = 2'd2
	} row_kind_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_DONE
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SRCH,
		BK_DECIDE,
		BK_NEW,
		BK_SEAL_CHK,
		BK_SEAL,
		BK_END
	} back_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             busy;
	} back_status_t;

endpackage

### sv/vqd_ram.sv
// Generic single write, single read RAM with registered read data
module vqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/vqd_front.sv
// Front end: snaps each coordinate to the grid with a bit-serial divider per lane
module vqd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_busy,
	input  logic signed [vqd_pkg::COORD_W-1:0] in_x,
	input  logic signed [vqd_pkg::COORD_W-1:0] in_y,
	input  logic signed [vqd_pkg::COORD_W-1:0] in_z,
	input  logic                              in_fin,
	input  logic [vqd_pkg::SIZE_W-1:0]        voxel_size,
	output logic                              out_valid,
	input  logic                              out_ready,
	output vqd_pkg::mid_item_t                out_item
);

	localparam int CW = vqd_pkg::COORD_W;
	localparam int NW = vqd_pkg::NUM_W;

	vqd_pkg::front_state_t state_q, state_d;

	logic [NW-1:0]          num_q   [3];
	logic [NW-1:0]          nsave_q [3];
	logic [CW-1:0]          rem_q   [3];
	logic                   neg_q   [3];
	logic [CW-1:0]          dvs_q;
	logic [vqd_pkg::STEP_W-1:0] step_q;
	logic                   fin_q;
	logic [CW-1:0]          coord_in [3];
	logic [CW-1:0]          snapped  [3];
	logic [vqd_pkg::SIZE_W-1:0] size_eff;
	logic                   accept;

	assign coord_in[0] = in_x;
	assign coord_in[1] = in_y;
	assign coord_in[2] = in_z;
	assign size_eff = (voxel_size == '0) ? vqd_pkg::SIZE_W'(1) : voxel_size;
	assign accept = in_valid && (state_q == vqd_pkg::FR_IDLE);

	// advance state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vqd_pkg::FR_IDLE: begin
				if (in_valid) state_d = vqd_pkg::FR_DIV;
			end
			vqd_pkg::FR_DIV: begin
				if (step_q == vqd_pkg::STEP_W'(1)) state_d = vqd_pkg::FR_DONE;
			end
			vqd_pkg::FR_DONE: begin
				if (out_ready) state_d = vqd_pkg::FR_IDLE;
			end
			default: state_d = vqd_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vqd_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// load numerator 2|c|+s, then one restoring step per cycle in every lane
	always_ff @(posedge clk) begin
		logic [CW-1:0] mag;
		logic [CW:0]   trial;
		if (accept) begin
			dvs_q  <= {size_eff, 1'b0};
			step_q <= vqd_pkg::STEP_W'(NW);
			fin_q  <= in_fin;
			for (int i = 0; i < 3; i++) begin
				mag = coord_in[i][CW-1] ? (~coord_in[i] + 1'b1) : coord_in[i];
				neg_q[i]   <= coord_in[i][CW-1];
				num_q[i]   <= {1'b0, mag, 1'b0} + NW'(size_eff);
				nsave_q[i] <= {1'b0, mag, 1'b0} + NW'(size_eff);
				rem_q[i]   <= '0;
			end
		end else if (state_q == vqd_pkg::FR_DIV) begin
			step_q <= step_q - 1'b1;
			for (int i = 0; i < 3; i++) begin
				trial = {rem_q[i], num_q[i][NW-1]};
				if (trial >= {1'b0, dvs_q}) begin
					rem_q[i] <= CW'(trial - {1'b0, dvs_q});
				end else begin
					rem_q[i] <= trial[CW-1:0];
				end
				num_q[i] <= {num_q[i][NW-2:0], 1'b0};
			end
		end
	end

	// product q*s equals (N - r) / 2; apply sign and saturate
	always_comb begin
		logic [NW-1:0] diff;
		logic [CW:0]   prod;
		for (int i = 0; i < 3; i++) begin
			diff = nsave_q[i] - NW'(rem_q[i]);
			prod = diff[NW-1:1];
			if (neg_q[i]) begin
				snapped[i] = (prod >= {1'b0, 32'h8000_0000}) ? 32'h8000_0000
					: (~prod[CW-1:0] + 1'b1);
			end else begin
				snapped[i] = (prod > {1'b0, 32'h7FFF_FFFF}) ? 32'h7FFF_FFFF
					: prod[CW-1:0];
			end
		end
	end

	assign in_busy      = (state_q != vqd_pkg::FR_IDLE);
	assign out_valid    = (state_q == vqd_pkg::FR_DONE);
	assign out_item.vox.x = snapped[0];
	assign out_item.vox.y = snapped[1];
	assign out_item.vox.z = snapped[2];
	assign out_item.fin   = fin_q;

endmodule

### sv/vqd_queue.sv
// Two-entry queue between the front and back ends
module vqd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  vqd_pkg::mid_item_t wr_item,
	output logic               rd_valid,
	input  logic               rd_ready,
	output vqd_pkg::mid_item_t rd_item
);

	vqd_pkg::mid_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	// store beat
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_item;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### sv/vqd_back.sv
// Back end: searches the unique table, stores new voxels and emits rows
module vqd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  vqd_pkg::mid_item_t        in_item,
	output logic                      row_valid,
	input  logic                      row_pop,
	output vqd_pkg::voxel_t           row_vox,
	output vqd_pkg::row_kind_t        row_kind,
	output logic                      row_ovf,
	output logic                      row_end,
	output vqd_pkg::back_status_t     status
);

	localparam int AW = vqd_pkg::ADDR_W;
	localparam int CNW = vqd_pkg::CNT_W;

	vqd_pkg::back_state_t state_q, state_d;

	vqd_pkg::mid_item_t item_q;
	logic [CNW-1:0]     k_q;
	logic [CNW-1:0]     count_q;
	logic [CNW-1:0]     count_m1;
	logic               cmp_vld_s1;
	logic               found_q;
	logic               rep_q;
	logic               drop_q;
	logic               out_vld_q;
	vqd_pkg::voxel_t    out_vox_q;
	vqd_pkg::row_kind_t out_kind_q;
	logic               out_ovf_q;
	logic               out_end_q;

	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [vqd_pkg::RAM_W-1:0] ram_rdata;
	logic               slot_free;
	logic               match;
	logic               full_tbl;
	logic               load_row;
	vqd_pkg::voxel_t    row_vox_d;
	vqd_pkg::row_kind_t row_kind_d;
	logic               row_end_d;

	vqd_ram #(
		.WIDTH(vqd_pkg::RAM_W),
		.DEPTH(vqd_pkg::MAX_VOXELS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (item_q.vox),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_free = !out_vld_q || row_pop;
	assign match     = cmp_vld_s1 && (ram_rdata == item_q.vox);
	assign full_tbl  = (count_q == CNW'(vqd_pkg::MAX_VOXELS));
	assign count_m1  = count_q - 1'b1;

	// next state, table access and row load
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = k_q[AW-1:0];
		load_row   = 1'b0;
		row_vox_d  = item_q.vox;
		row_kind_d = vqd_pkg::ROW_NEW;
		row_end_d  = 1'b0;
		unique case (state_q)
			vqd_pkg::BK_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = vqd_pkg::BK_SRCH;
			end
			vqd_pkg::BK_SRCH: begin
				if (match) begin
					state_d = vqd_pkg::BK_DECIDE;
				end else if (k_q < count_q) begin
					ram_re = 1'b1;
				end else if (!cmp_vld_s1) begin
					state_d = vqd_pkg::BK_DECIDE;
				end
			end
			vqd_pkg::BK_DECIDE: begin
				if (found_q || full_tbl) begin
					state_d = item_q.fin ? vqd_pkg::BK_SEAL_CHK : vqd_pkg::BK_IDLE;
				end else begin
					ram_we  = 1'b1;
					state_d = vqd_pkg::BK_NEW;
				end
			end
			vqd_pkg::BK_NEW: begin
				if (slot_free) begin
					load_row  = 1'b1;
					row_end_d = !item_q.fin;
					state_d   = item_q.fin ? vqd_pkg::BK_SEAL_CHK : vqd_pkg::BK_IDLE;
				end
			end
			vqd_pkg::BK_SEAL_CHK: begin
				if (rep_q && (count_q != '0)) begin
					ram_re    = 1'b1;
					ram_raddr = count_m1[AW-1:0];
					state_d   = vqd_pkg::BK_SEAL;
				end else begin
					state_d = vqd_pkg::BK_END;
				end
			end
			vqd_pkg::BK_SEAL: begin
				if (slot_free) begin
					load_row   = 1'b1;
					row_vox_d  = ram_rdata;
					row_kind_d = vqd_pkg::ROW_SEAL;
					state_d    = vqd_pkg::BK_END;
				end
			end
			vqd_pkg::BK_END: begin
				if (slot_free) begin
					load_row   = 1'b1;
					row_vox_d  = '0;
					row_kind_d = vqd_pkg::ROW_END;
					row_end_d  = 1'b1;
					state_d    = vqd_pkg::BK_IDLE;
				end
			end
			default: state_d = vqd_pkg::BK_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vqd_pkg::BK_IDLE;
			k_q        <= '0;
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			rep_q      <= 1'b0;
			drop_q     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vqd_pkg::BK_IDLE && in_valid) begin
				k_q        <= '0;
				cmp_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
			end
			if (state_q == vqd_pkg::BK_SRCH) begin
				cmp_vld_s1 <= ram_re;
				if (ram_re) k_q <= k_q + 1'b1;
				if (match) found_q <= 1'b1;
			end
			if (state_q == vqd_pkg::BK_DECIDE) begin
				if (found_q) rep_q <= 1'b1;
				else if (full_tbl) drop_q <= 1'b1;
				else count_q <= count_q + 1'b1;
			end
			// clear the table after the end row
			if (state_q == vqd_pkg::BK_END && slot_free) begin
				count_q <= '0;
				rep_q   <= 1'b0;
				drop_q  <= 1'b0;
			end
			if (load_row) out_vld_q <= 1'b1;
			else if (row_pop) out_vld_q <= 1'b0;
		end
	end

	// hold item and output row
	always_ff @(posedge clk) begin
		if (state_q == vqd_pkg::BK_IDLE && in_valid) item_q <= in_item;
		if (load_row) begin
			out_vox_q  <= row_vox_d;
			out_kind_q <= row_kind_d;
			out_ovf_q  <= drop_q;
			out_end_q  <= row_end_d;
		end
	end

	assign row_valid     = out_vld_q;
	assign row_vox       = out_vox_q;
	assign row_kind      = out_kind_q;
	assign row_ovf       = out_ovf_q;
	assign row_end       = out_end_q;
	assign status.count  = count_q;
	assign status.busy   = (state_q != vqd_pkg::BK_IDLE);

endmodule

### sv/voxel_quantize_dedup.sv
// Path: the front divider (34 restoring steps per lane, one hand-off), then the back end,
// which scans the stored voxels through one table read port before the first row.
// The front end takes a new point only after handing the last one on to the queue,
// and a row waits in the output register until it is popped.
// Reset: arst_n clears the queue, counters and flags; voxel_size returns to 65536.
`include "voxel_quantize_dedup_macros.svh"
module voxel_quantize_dedup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [vqd_pkg::COORD_W-1:0] point_x,
	input  logic signed [vqd_pkg::COORD_W-1:0] point_y,
	input  logic signed [vqd_pkg::COORD_W-1:0] point_z,
	input  logic                               final_point,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [vqd_pkg::COORD_W-1:0] vox_x,
	output logic signed [vqd_pkg::COORD_W-1:0] vox_y,
	output logic signed [vqd_pkg::COORD_W-1:0] vox_z,
	output logic [1:0]                         row_kind,
	output logic                               overflowed,
	output logic                               run_end,
	input  logic                               cfg_we,
	input  logic [vqd_pkg::SIZE_W-1:0]         cfg_data
);

	logic [vqd_pkg::SIZE_W-1:0] voxel_size_q;
	logic                  fr_valid;
	logic                  fr_ready;
	vqd_pkg::mid_item_t    fr_item;
	logic                  bk_valid;
	logic                  bk_ready;
	vqd_pkg::mid_item_t    bk_item;
	logic                  row_valid;
	vqd_pkg::voxel_t       row_vox;
	vqd_pkg::row_kind_t    row_kind_w;
	vqd_pkg::back_status_t bk_status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxel_size_q <= vqd_pkg::VOXEL_SIZE_RESET;
		end else if (cfg_we) begin
			voxel_size_q <= cfg_data;
		end
	end

	vqd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (push),
		.in_busy    (full),
		.in_x       (point_x),
		.in_y       (point_y),
		.in_z       (point_z),
		.in_fin     (final_point),
		.voxel_size (voxel_size_q),
		.out_valid  (fr_valid),
		.out_ready  (fr_ready),
		.out_item   (fr_item)
	);

	vqd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_item  (fr_item),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_item  (bk_item)
	);

	vqd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bk_valid),
		.in_ready  (bk_ready),
		.in_item   (bk_item),
		.row_valid (row_valid),
		.row_pop   (pop),
		.row_vox   (row_vox),
		.row_kind  (row_kind_w),
		.row_ovf   (overflowed),
		.row_end   (run_end),
		.status    (bk_status)
	);

	assign empty    = !row_valid;
	assign vox_x    = row_vox.x;
	assign vox_y    = row_vox.y;
	assign vox_z    = row_vox.z;
	assign row_kind = row_kind_w;

	// checks
	`VQD_ASSERT_NOW(a_count_bound, 1'b1, bk_status.count <= vqd_pkg::CNT_W'(vqd_pkg::MAX_VOXELS))
	`VQD_ASSERT_NOW(a_end_row_closes, !empty && row_kind == vqd_pkg::ROW_END, run_end && vox_x == '0)
	`VQD_ASSERT_NOW(a_seal_not_last, !empty && row_kind == vqd_pkg::ROW_SEAL, !run_end)
	`VQD_ASSERT_NEXT(a_end_clears, !empty && pop && row_kind == vqd_pkg::ROW_END, bk_status.count <= vqd_pkg::CNT_W'(1))

endmodule

### verif/voxel_quantize_dedup_test.sv
// Testbench for voxel_quantize_dedup: self-checking against an in-bench voxel table model
`timescale 1ns / 100ps
module voxel_quantize_dedup_test;

	localparam int SETTLE_CYCLES = 1100;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_PER_PHASE = 40;

	typedef struct {
		logic [vqd_pkg::COORD_W-1:0] x;
		logic [vqd_pkg::COORD_W-1:0] y;
		logic [vqd_pkg::COORD_W-1:0] z;
		vqd_pkg::row_kind_t          kind;
		logic                        ovf;
		logic                        last;
	} vox_row_t;

	// Voxel table model: snaps points, keeps distinct voxels, queues the rows they cause
	class voxel_dedup_table;
		logic [vqd_pkg::SIZE_W-1:0] size;
		logic [vqd_pkg::RAM_W-1:0]  stored[vqd_pkg::MAX_VOXELS];
		int                         count;
		bit                         repeat_hit;
		bit                         dropped;
		vox_row_t                   pending_rows[$];

		function new();
			size = vqd_pkg::VOXEL_SIZE_RESET;
			count = 0;
			repeat_hit = 0;
			dropped = 0;
		endfunction

		// Round half away from zero, scale back, saturate
		function logic [vqd_pkg::COORD_W-1:0] snap(logic [vqd_pkg::COORD_W-1:0] c);
			logic [63:0] a;
			logic [63:0] s;
			logic [63:0] q;
			logic [63:0] prod;
			logic [vqd_pkg::COORD_W-1:0] mag;
			mag = -c;
			s = (size == 0) ? 64'd1 : {33'd0, size};
			a = c[vqd_pkg::COORD_W-1] ? {32'd0, mag} : {32'd0, c};
			q = (2 * a + s) / (2 * s);
			prod = q * s;
			if (c[vqd_pkg::COORD_W-1]) begin
				if (prod >= 64'h8000_0000)
					return 32'h8000_0000;
				return -prod[vqd_pkg::COORD_W-1:0];
			end
			if (prod > 64'h7FFF_FFFF)
				return 32'h7FFF_FFFF;
			return prod[vqd_pkg::COORD_W-1:0];
		endfunction

		function void add_row(logic [vqd_pkg::RAM_W-1:0] v, vqd_pkg::row_kind_t kind);
			vox_row_t r;
			{r.x, r.y, r.z} = v;
			r.kind = kind;
			r.ovf = dropped;
			r.last = 0;
			pending_rows.push_back(r);
		endfunction

		function void note_point(logic [vqd_pkg::COORD_W-1:0] px,
				logic [vqd_pkg::COORD_W-1:0] py,
				logic [vqd_pkg::COORD_W-1:0] pz, logic fin);
			logic [vqd_pkg::RAM_W-1:0] key;
			bit found;
			int before_n;
			vox_row_t r;
			before_n = pending_rows.size();
			key = {snap(px), snap(py), snap(pz)};
			found = 0;
			for (int k = 0; k < count; k++) begin
				if (stored[k] == key) begin
					found = 1;
					break;
				end
			end
			if (found) begin
				repeat_hit = 1;
			end else if (count >= vqd_pkg::MAX_VOXELS) begin
				dropped = 1;
			end else begin
				stored[count] = key;
				count++;
				add_row(key, vqd_pkg::ROW_NEW);
			end
			// close the set: optional seal of the last voxel, then the end row
			if (fin) begin
				if (repeat_hit && count > 0)
					add_row(stored[count-1], vqd_pkg::ROW_SEAL);
				add_row('0, vqd_pkg::ROW_END);
				count = 0;
				repeat_hit = 0;
				dropped = 0;
			end
			if (pending_rows.size() > before_n) begin
				r = pending_rows.pop_back();
				r.last = 1;
				pending_rows.push_back(r);
			end
		endfunction

		// Return an empty string on a match, else a description of the first bad field
		function string check_row(vox_row_t got);
			vox_row_t want;
			if (pending_rows.size() == 0)
				return $sformatf("unexpected row x=%h kind=%0d", got.x, got.kind);
			want = pending_rows.pop_front();
			if (got.x !== want.x)
				return $sformatf("vox_x %h, want %h", got.x, want.x);
			if (got.y !== want.y)
				return $sformatf("vox_y %h, want %h", got.y, want.y);
			if (got.z !== want.z)
				return $sformatf("vox_z %h, want %h", got.z, want.z);
			if (got.kind !== want.kind)
				return $sformatf("row_kind %0d, want %0d", got.kind, want.kind);
			if (got.ovf !== want.ovf)
				return $sformatf("overflowed %b, want %b", got.ovf, want.ovf);
			if (got.last !== want.last)
				return $sformatf("run_end %b, want %b", got.last, want.last);
			return "";
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic signed [vqd_pkg::COORD_W-1:0] point_x = '0;
	logic signed [vqd_pkg::COORD_W-1:0] point_y = '0;
	logic signed [vqd_pkg::COORD_W-1:0] point_z = '0;
	logic final_point = 0;
	logic empty;
	logic pop = 0;
	logic signed [vqd_pkg::COORD_W-1:0] vox_x;
	logic signed [vqd_pkg::COORD_W-1:0] vox_y;
	logic signed [vqd_pkg::COORD_W-1:0] vox_z;
	logic [1:0] row_kind;
	logic overflowed;
	logic run_end;
	logic cfg_we = 0;
	logic [vqd_pkg::SIZE_W-1:0] cfg_data = '0;

	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles = 0;
	voxel_dedup_table table_model = new();

	voxel_quantize_dedup dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.final_point(final_point),
		.empty(empty), .pop(pop),
		.vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z),
		.row_kind(row_kind), .overflowed(overflowed), .run_end(run_end),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Offer one point, hold it until the beat is taken
	task automatic send_point(logic [vqd_pkg::COORD_W-1:0] x, logic [vqd_pkg::COORD_W-1:0] y,
			logic [vqd_pkg::COORD_W-1:0] z, logic fin);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		push <= 1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		final_point <= fin;
		do @(posedge clk); while (full);
		table_model.note_point(x, y, z, fin);
		@(negedge clk);
	endtask

	// Drain, let the back end settle, then write the voxel size
	task automatic set_voxel_size(logic [vqd_pkg::SIZE_W-1:0] v);
		push <= 0;
		while (table_model.pending_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		table_model.size = v;
	endtask

	// Mostly points near the grid so repeats happen, some anywhere
	function automatic logic [vqd_pkg::COORD_W-1:0] pick_coord();
		logic [vqd_pkg::COORD_W-1:0] s;
		logic [vqd_pkg::COORD_W-1:0] cell_no;
		s = {1'b0, table_model.size};
		if ($urandom_range(9) < 7) begin
			cell_no = $urandom_range(8) - 4;
			return cell_no * s + ($urandom % ({1'b0, s[vqd_pkg::COORD_W-1:1]} + 1));
		end
		return $urandom;
	endfunction

	task automatic send_random_sets(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				send_point(pick_coord(), pick_coord(), pick_coord(),
					(i == len - 1) || ($urandom_range(19) == 0));
				sent++;
			end
		end
	endtask

	// Receiver: pop at random, check each beat taken
	initial begin
		vox_row_t got;
		string msg;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got.x = vox_x;
				got.y = vox_y;
				got.z = vox_z;
				got.kind = vqd_pkg::row_kind_t'(row_kind);
				got.ovf = overflowed;
				got.last = run_end;
				msg = table_model.check_row(got);
				if (msg != "")
					report(msg);
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("voxel_quantize_dedup: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 87 : 0;
			recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 18 : 0;
			if (ph == 0) begin
				// reset size: half steps, saturation, repeat and seal
				send_point(0, 0, 0, 1'b0);
				send_point(0, 0, 0, 1'b0);
				send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF, 1'b0);
				send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1);
				send_point(32'hFFFF_7FFF, 32'h0001_8000, 32'h0, 1'b1);
				// largest voxel
				set_voxel_size(31'h7FFF_FFFF);
				send_point(32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 1'b0);
				send_point(32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1);
				// smallest voxel
				set_voxel_size(31'd1);
				send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
				// odd size, negative halves
				set_voxel_size(31'd3);
				send_point(32'd1, 32'd2, -32'sd2, 1'b0);
				send_point(-32'sd1, 32'd4, -32'sd4, 1'b0);
				send_point(32'd5, 32'd5, 32'd5, 1'b1);
				set_voxel_size(31'd65536);
			end else if (ph == 1) begin
				set_voxel_size(vqd_pkg::SIZE_W'($urandom_range(2, 1 << 22)));
			end else begin
				set_voxel_size(31'd1);
			end
			send_random_sets(RANDOM_PER_PHASE);
		end

		push <= 0;
		while (table_model.pending_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("voxel_quantize_dedup: match");
		else
			$display("voxel_quantize_dedup: mismatch");
		$finish;
	end

endmodule
